>>> rtl/hsv_color_blob_centroid_unit_macros.svh
// Assertion helpers shared by the checker
`ifndef HSV_COLOR_BLOB_CENTROID_UNIT_MACROS_SVH
`define HSV_COLOR_BLOB_CENTROID_UNIT_MACROS_SVH

// same-cycle implication
`define HCBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbc check failed");

// next-cycle implication
`define HCBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbc check failed");

`endif

>>> rtl/hcbc_pkg.sv
`timescale 1ns / 1ps
package hcbc_pkg;

  localparam int AREA_W       = 23;
  localparam int COORD_W      = 11;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int CFG_AW       = 5;

  localparam logic [AREA_W-1:0] AREA_MAX = 23'h7FFFFF;

  // register indexes (word address)
  localparam logic [2:0] REG_MARKER_LOW  = 3'd0;
  localparam logic [2:0] REG_MARKER_HIGH = 3'd1;
  localparam logic [2:0] REG_OBJECT_LOW  = 3'd2;
  localparam logic [2:0] REG_OBJECT_HIGH = 3'd3;
  localparam logic [2:0] REG_OBJECT_AREA = 3'd4;

  localparam logic [23:0] RST_MARKER_LOW  = 24'h00C900;
  localparam logic [23:0] RST_MARKER_HIGH = 24'hB3FFFF;
  localparam logic [23:0] RST_OBJECT_LOW  = 24'h233C28;
  localparam logic [23:0] RST_OBJECT_HIGH = 24'h55FFFF;
  localparam logic [AREA_W-1:0] RST_OBJECT_AREA = 23'd10;

  // fixed-point numerators of the rounded reciprocals
  localparam logic [21:0] SAT_NUM = 22'd2088960;
  localparam logic [17:0] HUE_NUM = 18'd245760;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       end_of_line;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] marker_x;
    logic [COORD_W-1:0] marker_y;
    logic               marker_found;
    logic [AREA_W-1:0]  marker_area;
    logic [COORD_W-1:0] object_x;
    logic [COORD_W-1:0] object_y;
    logic               object_found;
    logic [AREA_W-1:0]  object_area;
    logic               object_seen;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_SDIV_GO, ST_SDIV, ST_HDIV_GO, ST_HDIV, ST_SAT, ST_HUE,
    ST_ACC, ST_MX_GO, ST_MX, ST_MY_GO, ST_MY, ST_OX_GO, ST_OX, ST_OY_GO, ST_OY,
    ST_PUB
  } state_t;

  typedef enum logic [2:0] {
    DSEL_SD, DSEL_HD, DSEL_MX, DSEL_MY, DSEL_OX, DSEL_OY
  } div_sel_t;

  typedef struct packed {
    logic     load_pix;
    logic     prep;
    logic     div_start;
    logic     div_cap;
    div_sel_t div_sel;
    logic     sat;
    logic     hue;
    logic     acc;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic frame_end;
    logic out_free;
  } status_t;

endpackage

>>> rtl/hsv_color_blob_centroid_unit.sv
`timescale 1ns / 1ps
// HSV colour-window blob centroid for a marker and an object target.
// Input channel in_*: one BGR pixel per request in raster order, with
// end_of_line and end_of_frame marks. Result channel out_*: one request per
// frame, issued after the pixel marked end_of_frame, with floored centroids,
// areas, found flags and the sticky object-seen flag.
// Configuration: APB-style cfg_* port, windows at 0x0..0xC, minimum object
// area at 0x10; write only while the block is idle.
// Pixels: the one-bit-per-cycle divider (DW bits wide, DW being 23 plus
// the coordinate width) is used twice per pixel for the saturation and hue
// reciprocals; the next pixel is taken only once the last one is through.
// Frame end adds four more divisions for the centroids before the result
// is loaded into the output register.
// Reset clears position, accumulators, the seen flag and the window
// registers to their defaults. A stalled result stays in the output
// register; the block keeps taking pixels meanwhile and only waits if the
// next frame result is ready before the old one has been taken.
module hsv_color_blob_centroid_unit #(
  parameter int MAX_WIDTH  = hcbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hcbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hcbc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hcbc_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hcbc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import hcbc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_pready = 1'b1;

  hcbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcbc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cmd         (cmd),
    .sts         (sts)
  );
endmodule

>>> rtl/hcbc_div.sv
`timescale 1ns / 1ps
module hcbc_div #(
  parameter int W   = 34,
  parameter int DVW = 23
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   dividend,
  input  logic [DVW-1:0] divisor,
  output logic [W-1:0]   quotient,
  output logic           done
);
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r, quo_nxt;
  logic [DVW-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVW:0]     trial;

  // one restoring step per cycle, MSB first
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    trial    = {rem_r, quo_r[W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DVW'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVW-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

>>> rtl/hcbc_ctrl.sv
`timescale 1ns / 1ps
module hcbc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hcbc_pkg::status_t sts,
  output hcbc_pkg::cmd_t    cmd
);
  import hcbc_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_PREP;
      ST_PREP:    state_nxt = ST_SDIV_GO;
      ST_SDIV_GO: state_nxt = ST_SDIV;
      ST_SDIV:    if (sts.div_done) state_nxt = ST_HDIV_GO;
      ST_HDIV_GO: state_nxt = ST_HDIV;
      ST_HDIV:    if (sts.div_done) state_nxt = ST_SAT;
      ST_SAT:     state_nxt = ST_HUE;
      ST_HUE:     state_nxt = ST_ACC;
      ST_ACC:     state_nxt = sts.frame_end ? ST_MX_GO : ST_IDLE;
      ST_MX_GO:   state_nxt = ST_MX;
      ST_MX:      if (sts.div_done) state_nxt = ST_MY_GO;
      ST_MY_GO:   state_nxt = ST_MY;
      ST_MY:      if (sts.div_done) state_nxt = ST_OX_GO;
      ST_OX_GO:   state_nxt = ST_OX;
      ST_OX:      if (sts.div_done) state_nxt = ST_OY_GO;
      ST_OY_GO:   state_nxt = ST_OY;
      ST_OY:      if (sts.div_done) state_nxt = ST_PUB;
      ST_PUB:     if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_pix = in_valid;
      end
      ST_PREP:    cmd.prep = 1'b1;
      ST_SDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_SD;
      end
      ST_SDIV: begin
        cmd.div_cap = sts.div_done;
        cmd.div_sel = DSEL_SD;
      end
      ST_HDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_HD;
      end
      ST_HDIV: begin
        cmd.div_cap = sts.div_done;
        cmd.div_sel = DSEL_HD;
      end
      ST_SAT:     cmd.sat = 1'b1;
      ST_HUE:     cmd.hue = 1'b1;
      ST_ACC:     cmd.acc = 1'b1;
      ST_MX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MX;
      end
      ST_MX: begin
        cmd.div_cap = sts.div_done;
        cmd.div_sel = DSEL_MX;
      end
      ST_MY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MY;
      end
      ST_MY: begin
        cmd.div_cap = sts.div_done;
        cmd.div_sel = DSEL_MY;
      end
      ST_OX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_OX;
      end
      ST_OX: begin
        cmd.div_cap = sts.div_done;
        cmd.div_sel = DSEL_OX;
      end
      ST_OY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_OY;
      end
      ST_OY: begin
        cmd.div_cap = sts.div_done;
        cmd.div_sel = DSEL_OY;
      end
      ST_PUB:     cmd.publish = sts.out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

>>> rtl/hcbc_datapath.sv
`timescale 1ns / 1ps
module hcbc_datapath #(
  parameter int MAX_WIDTH  = hcbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hcbc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hcbc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hcbc_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hcbc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  input  hcbc_pkg::cmd_t              cmd,
  output hcbc_pkg::status_t           sts
);
  import hcbc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int PW  = (CW > RW) ? CW : RW;
  localparam int DW  = AREA_W + PW;
  localparam int CSW = AREA_W + CW;
  localparam int RSW = AREA_W + RW;

  // configuration registers
  logic [23:0]       mlo_r, mhi_r, olo_r, ohi_r;
  logic [AREA_W-1:0] omin_r;
  logic [2:0]        cfg_idx;
  logic              cfg_wr;

  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlo_r  <= RST_MARKER_LOW;
      mhi_r  <= RST_MARKER_HIGH;
      olo_r  <= RST_OBJECT_LOW;
      ohi_r  <= RST_OBJECT_HIGH;
      omin_r <= RST_OBJECT_AREA;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MARKER_LOW:  mlo_r  <= cfg_pwdata[23:0];
        REG_MARKER_HIGH: mhi_r  <= cfg_pwdata[23:0];
        REG_OBJECT_LOW:  olo_r  <= cfg_pwdata[23:0];
        REG_OBJECT_HIGH: ohi_r  <= cfg_pwdata[23:0];
        REG_OBJECT_AREA: omin_r <= cfg_pwdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MARKER_LOW:  cfg_prdata = {8'd0, mlo_r};
      REG_MARKER_HIGH: cfg_prdata = {8'd0, mhi_r};
      REG_OBJECT_LOW:  cfg_prdata = {8'd0, olo_r};
      REG_OBJECT_HIGH: cfg_prdata = {8'd0, ohi_r};
      REG_OBJECT_AREA: cfg_prdata = 32'(omin_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // pixel request latch
  in_item_t pix_r;
  always_ff @(posedge clk) begin
    if (cmd.load_pix) pix_r <= in_data;
  end

  // max/min, hue difference and gray test
  logic [7:0]         mx, mn;
  logic [7:0]         mx_r, delta_r;
  logic signed [11:0] diff, diff_r;
  logic [24:0]        gsum;
  logic               lit_r;

  always_comb begin
    mx = pix_r.red;
    mn = pix_r.red;
    if (pix_r.green > mx) mx = pix_r.green;
    if (pix_r.blue > mx)  mx = pix_r.blue;
    if (pix_r.green < mn) mn = pix_r.green;
    if (pix_r.blue < mn)  mn = pix_r.blue;
    if (mx == pix_r.red)
      diff = $signed({4'd0, pix_r.green}) - $signed({4'd0, pix_r.blue});
    else if (mx == pix_r.green)
      diff = $signed({4'd0, pix_r.blue}) - $signed({4'd0, pix_r.red})
           + $signed({3'd0, 8'(mx - mn), 1'b0});
    else
      diff = $signed({4'd0, pix_r.red}) - $signed({4'd0, pix_r.green})
           + $signed({2'd0, 8'(mx - mn), 2'b0});
    gsum = 25'(pix_r.red) * 25'd4899 + 25'(pix_r.green) * 25'd9617
         + 25'(pix_r.blue) * 25'd1868 + 25'd8192;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mx_r    <= mx;
      delta_r <= 8'(mx - mn);
      diff_r  <= diff;
      lit_r   <= (gsum[24:14] != 11'd0);
    end
  end

  // shared divider
  logic [DW-1:0]     div_num, quo;
  logic [AREA_W-1:0] div_den;
  logic              div_done;

  logic [CSW-1:0]    mcs_r, ocs_r;
  logic [RSW-1:0]    mrs_r, ors_r;
  logic [AREA_W-1:0] mtot_r, otot_r;

  always_comb begin
    case (cmd.div_sel)
      DSEL_SD: begin
        div_num = DW'(SAT_NUM + 22'(mx_r));
        div_den = AREA_W'({mx_r, 1'b0});
      end
      DSEL_HD: begin
        div_num = DW'(HUE_NUM + 18'(delta_r));
        div_den = AREA_W'({delta_r, 1'b0});
      end
      DSEL_MX: begin
        div_num = DW'(mcs_r);
        div_den = mtot_r;
      end
      DSEL_MY: begin
        div_num = DW'(mrs_r);
        div_den = mtot_r;
      end
      DSEL_OX: begin
        div_num = DW'(ocs_r);
        div_den = otot_r;
      end
      DSEL_OY: begin
        div_num = DW'(ors_r);
        div_den = otot_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  hcbc_div #(.W(DW), .DVW(AREA_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (quo),
    .done     (div_done)
  );

  logic [20:0]        sd_r;
  logic [16:0]        hd_r;
  logic [COORD_W-1:0] qmx_r, qmy_r, qox_r, qoy_r;

  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.div_sel)
        DSEL_SD: sd_r  <= quo[20:0];
        DSEL_HD: hd_r  <= quo[16:0];
        DSEL_MX: qmx_r <= quo[COORD_W-1:0];
        DSEL_MY: qmy_r <= quo[COORD_W-1:0];
        DSEL_OX: qox_r <= quo[COORD_W-1:0];
        DSEL_OY: qoy_r <= quo[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // saturation and hue
  logic [28:0]        sprod;
  logic signed [31:0] hval, hh;
  logic [7:0]         s_r, h_r;

  always_comb begin
    sprod = 29'(delta_r) * 29'(sd_r) + 29'd2048;
    hval  = 32'(diff_r) * $signed({15'd0, hd_r}) + 32'sd264192;
    hh    = (hval >>> 12) - 32'sd64;
    if (hh < 0) hh = hh + 32'sd180;
  end

  always_ff @(posedge clk) begin
    if (cmd.sat) s_r <= (mx_r == 8'd0) ? 8'd0 : sprod[19:12];
    if (cmd.hue) h_r <= (delta_r == 8'd0) ? 8'd0 : hh[7:0];
  end

  // window tests
  function automatic logic in_win(input logic [23:0] lo, input logic [23:0] hi,
                                  input logic [7:0] h, input logic [7:0] s,
                                  input logic [7:0] v);
    in_win = (h >= lo[23:16]) && (h <= hi[23:16]) && (s >= lo[15:8]) &&
             (s <= hi[15:8]) && (v >= lo[7:0]) && (v <= hi[7:0]);
  endfunction

  logic m_hit, o_hit;
  assign m_hit = lit_r && in_win(mlo_r, mhi_r, h_r, s_r, mx_r) && (mtot_r != AREA_MAX);
  assign o_hit = lit_r && in_win(olo_r, ohi_r, h_r, s_r, mx_r) && (otot_r != AREA_MAX);

  // position and accumulators
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          seen_r;
  logic          m_found, o_found;

  assign m_found = (mtot_r != '0);
  assign o_found = (otot_r != '0) && (otot_r >= omin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      mtot_r <= '0;
      otot_r <= '0;
      mcs_r  <= '0;
      mrs_r  <= '0;
      ocs_r  <= '0;
      ors_r  <= '0;
      seen_r <= 1'b0;
    end else if (cmd.acc) begin
      if (m_hit) begin
        mtot_r <= mtot_r + AREA_W'(1);
        mcs_r  <= mcs_r + CSW'(col_r);
        mrs_r  <= mrs_r + RSW'(row_r);
      end
      if (o_hit) begin
        otot_r <= otot_r + AREA_W'(1);
        ocs_r  <= ocs_r + CSW'(col_r);
        ors_r  <= ors_r + RSW'(row_r);
      end
      if (pix_r.end_of_frame) begin
        col_r <= '0;
        row_r <= '0;
      end else if (pix_r.end_of_line) begin
        col_r <= '0;
        if (row_r < RW'(MAX_HEIGHT - 1)) row_r <= row_r + RW'(1);
      end else if (col_r < CW'(MAX_WIDTH - 1)) begin
        col_r <= col_r + CW'(1);
      end
    end else if (cmd.publish) begin
      mtot_r <= '0;
      otot_r <= '0;
      mcs_r  <= '0;
      mrs_r  <= '0;
      ocs_r  <= '0;
      ors_r  <= '0;
      if (o_found) seen_r <= 1'b1;
    end
  end

  // result register
  out_item_t out_r;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_r.marker_x     <= m_found ? qmx_r : '0;
      out_r.marker_y     <= m_found ? qmy_r : '0;
      out_r.marker_found <= m_found;
      out_r.marker_area  <= mtot_r;
      out_r.object_x     <= o_found ? qox_r : '0;
      out_r.object_y     <= o_found ? qoy_r : '0;
      out_r.object_found <= o_found;
      out_r.object_area  <= otot_r;
      out_r.object_seen  <= seen_r || o_found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)           out_valid_r <= 1'b0;
    else if (cmd.publish) out_valid_r <= 1'b1;
    else if (!out_stall)  out_valid_r <= 1'b0;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.div_done  = div_done;
  assign sts.frame_end = pix_r.end_of_frame;
  assign sts.out_free  = !out_valid_r || !out_stall;
endmodule

>>> rtl/hcbc_checker.sv
`timescale 1ns / 1ps
`include "hsv_color_blob_centroid_unit_macros.svh"
module hcbc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hcbc_pkg::out_item_t out_data
);
  import hcbc_pkg::*;

  // a held result does not move
  `HCBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, $stable(out_data))
  // one pixel at a time: busy right after a request
  `HCBC_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)
  // seen flag covers the current frame
  `HCBC_ASSERT_NOW(a_seen, clk, rst_n, out_valid && out_data.object_found,
                   out_data.object_seen)
  // empty marker reports origin
  `HCBC_ASSERT_NOW(a_marker_zero, clk, rst_n, out_valid && !out_data.marker_found,
                   out_data.marker_x == '0 && out_data.marker_y == '0 &&
                   out_data.marker_area == '0)
endmodule

bind hsv_color_blob_centroid_unit hcbc_checker u_hcbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
